### design/hds_pkg.sv
// Shared constants, codes and types of the heat diffusion stencil step block.
`timescale 1ns / 1ps
package hds_pkg;

  localparam int TEMP_W     = 18;
  localparam int SIZE_W     = 6;
  localparam int COEF_W     = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // Datapath widths of the stencil arithmetic
  localparam int LAP_W   = TEMP_W + 2;
  localparam int PROD_W  = LAP_W + COEF_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int FRAC_W  = 24;
  localparam int DELTA_W = SUM_W - FRAC_W;

  localparam int MAX_COLUMNS_DEF = 32;
  localparam int MAX_ROWS_DEF    = 32;
  localparam int MIN_SIZE        = 3;

  // Result entries held between the stencil pipeline and the output channel
  localparam int OUTQ_DEPTH = 8;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(25);
  localparam logic [COEF_W-1:0] COEF_RST = COEF_W'(8389);

  typedef logic signed [TEMP_W-1:0] temp_t;

  localparam temp_t TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
  localparam temp_t TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS = 2'd0,
    CFG_GRID_ROWS    = 2'd1,
    CFG_COEF_HORIZ   = 2'd2,
    CFG_COEF_VERT    = 2'd3
  } hds_cfg_idx_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic need;      // item yields a result for the row above
    logic pass;      // item also yields its own last-row cell
    logic last;      // item is the last column
    logic interior;  // row-above cell gets the stencil update
  } hds_ctl_t;

  // One queue entry: the row-above result and the optional last-row cell
  typedef struct packed {
    temp_t temp_a;
    logic  has_b;
    temp_t temp_b;
    logic  last_b;
  } hds_res_t;

endpackage

### design/hds_if.sv
// Valid/ready channel interfaces for temperature requests and results.
`timescale 1ns / 1ps
interface hds_in_if;
  logic                 valid;
  logic                 ready;
  hds_pkg::temp_t       temp_in;

  modport source (output valid, output temp_in, input ready);
  modport sink (input valid, input temp_in, output ready);
endinterface

interface hds_out_if;
  logic                 valid;
  logic                 ready;
  hds_pkg::temp_t       temp_out;
  logic                 frame_last;

  modport source (output valid, output temp_out, output frame_last, input ready);
  modport sink (input valid, input temp_out, input frame_last, output ready);
endinterface

### design/hds_linebuf.sv
// Two row line buffers with registered reads and the left-neighbor register.
`timescale 1ns / 1ps
module hds_linebuf #(
  parameter int MAX_COLUMNS = hds_pkg::MAX_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(MAX_COLUMNS)-1:0] rd_col,
  input  logic [$clog2(MAX_COLUMNS)-1:0] rd_col_next,
  input  hds_pkg::temp_t                 wr_down,
  input  logic                           wb_en,
  input  logic [$clog2(MAX_COLUMNS)-1:0] wb_col,
  output hds_pkg::temp_t                 centre,
  output hds_pkg::temp_t                 right,
  output hds_pkg::temp_t                 up,
  output hds_pkg::temp_t                 left
);

  hds_pkg::temp_t prior_mem [MAX_COLUMNS];
  hds_pkg::temp_t older_mem [MAX_COLUMNS];
  hds_pkg::temp_t centre_r, right_r, up_r, left_r;

  // Read old values, then store the incoming row
  always_ff @(posedge clk) begin
    if (rd_en) begin
      centre_r            <= prior_mem[rd_col];
      right_r             <= prior_mem[rd_col_next];
      prior_mem[rd_col]   <= wr_down;
    end
  end

  // Move the row above down into the older buffer in the cycle after it is read out
  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_r <= older_mem[rd_col];
    end
    if (wb_en) begin
      older_mem[wb_col] <= centre_r;
    end
  end

  // Hold the previous column's centre as the next left neighbor
  always_ff @(posedge clk) begin
    if (wb_en) begin
      left_r <= centre_r;
    end
  end

  assign centre = centre_r;
  assign right  = right_r;
  assign up     = up_r;
  assign left   = left_r;

endmodule

### design/hds_stencil.sv
// Five-point stencil arithmetic: laplacians, coefficient products, rounding, saturation.
`timescale 1ns / 1ps
module hds_stencil (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  hds_pkg::hds_ctl_t             s1_ctl,
  input  hds_pkg::temp_t                s1_down,
  input  hds_pkg::temp_t                centre,
  input  hds_pkg::temp_t                right,
  input  hds_pkg::temp_t                up,
  input  hds_pkg::temp_t                left,
  input  logic [hds_pkg::COEF_W-1:0]    coef_h,
  input  logic [hds_pkg::COEF_W-1:0]    coef_v,
  output logic                          push,
  output hds_pkg::hds_res_t             push_data
);

  localparam int LAP_W   = hds_pkg::LAP_W;
  localparam int PROD_W  = hds_pkg::PROD_W;
  localparam int SUM_W   = hds_pkg::SUM_W;
  localparam int FRAC_W  = hds_pkg::FRAC_W;
  localparam int DELTA_W = hds_pkg::DELTA_W;
  localparam int NEW_W   = DELTA_W + 1;
  localparam logic signed [SUM_W-1:0] RND_HALF =
    {{(SUM_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

  logic signed [LAP_W-1:0]    lap_x, lap_y, lap_x_r, lap_y_r;
  logic signed [hds_pkg::COEF_W:0] coef_h_s, coef_v_s;
  logic signed [PROD_W-1:0]   prod_x, prod_y, prod_x_r, prod_y_r;
  logic signed [SUM_W-1:0]    sum_rnd;
  logic signed [DELTA_W-1:0]  delta;
  logic signed [NEW_W-1:0]    new_val;
  hds_pkg::temp_t             sat_val;
  hds_pkg::temp_t             centre2_r, down2_r, centre3_r, down3_r;
  hds_pkg::hds_ctl_t          ctl2_r, ctl3_r;
  logic                       s2_valid_r, s3_valid_r;

  // Stage 1: laplacians from the window
  assign lap_x = LAP_W'(left) + LAP_W'(right) - (LAP_W'(centre) <<< 1);
  assign lap_y = LAP_W'(up) + LAP_W'(s1_down) - (LAP_W'(centre) <<< 1);

  // Stage 2: coefficient products
  assign coef_h_s = {1'b0, coef_h};
  assign coef_v_s = {1'b0, coef_v};
  assign prod_x   = lap_x_r * coef_h_s;
  assign prod_y   = lap_y_r * coef_v_s;

  // Stage 3: round half up, add to centre, saturate
  assign sum_rnd = SUM_W'(prod_x_r) + SUM_W'(prod_y_r) + RND_HALF;
  assign delta   = $signed(sum_rnd[SUM_W-1:FRAC_W]);
  assign new_val = NEW_W'(delta) + NEW_W'(centre3_r);

  always_comb begin
    if (new_val > NEW_W'(hds_pkg::TEMP_MAX)) begin
      sat_val = hds_pkg::TEMP_MAX;
    end else if (new_val < NEW_W'(hds_pkg::TEMP_MIN)) begin
      sat_val = hds_pkg::TEMP_MIN;
    end else begin
      sat_val = new_val[hds_pkg::TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    lap_x_r   <= lap_x;
    lap_y_r   <= lap_y;
    centre2_r <= centre;
    down2_r   <= s1_down;
    ctl2_r    <= s1_ctl;
    prod_x_r  <= prod_x;
    prod_y_r  <= prod_y;
    centre3_r <= centre2_r;
    down3_r   <= down2_r;
    ctl3_r    <= ctl2_r;
  end

  assign push             = s3_valid_r & ctl3_r.need;
  assign push_data.temp_a = ctl3_r.interior ? sat_val : centre3_r;
  assign push_data.has_b  = ctl3_r.pass;
  assign push_data.temp_b = down3_r;
  assign push_data.last_b = ctl3_r.last;

endmodule

### design/hds_outq.sv
// Result queue with credit reservation, unpacking one or two results per entry.
`timescale 1ns / 1ps
module hds_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               reserve,
  output logic               credit_ok,
  input  logic               push,
  input  hds_pkg::hds_res_t  push_data,
  hds_out_if.source          out_ch
);

  localparam int DEPTH = hds_pkg::OUTQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  hds_pkg::hds_res_t q_mem [DEPTH];
  hds_pkg::hds_res_t head;
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     q_cnt_r, q_cnt_nxt, res_cnt_r, res_cnt_nxt;
  logic              half_r, half_nxt;
  logic              take, retire;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  assign head               = q_mem[rd_ptr_r];
  assign out_ch.valid       = (q_cnt_r != '0);
  assign out_ch.temp_out    = half_r ? head.temp_b : head.temp_a;
  assign out_ch.frame_last  = half_r & head.last_b;

  assign take   = out_ch.valid & out_ch.ready;
  assign retire = take & (half_r | ~head.has_b);

  assign credit_ok = (res_cnt_r < CW'(DEPTH));

  always_comb begin
    q_cnt_nxt   = q_cnt_r + CW'(push) - CW'(retire);
    res_cnt_nxt = res_cnt_r + CW'(reserve) - CW'(retire);
    half_nxt    = half_r;
    if (take) begin
      half_nxt = ~retire;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_cnt_r   <= '0;
      res_cnt_r <= '0;
      half_r    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (retire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      q_cnt_r   <= q_cnt_nxt;
      res_cnt_r <= res_cnt_nxt;
      half_r    <= half_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (q_cnt_r < CW'(DEPTH)))
    else $error("result queue written while full");

  a_reserve_covers: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= res_cnt_r)
    else $error("queued entries exceed reserved credits");

  a_half_only_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (half_r && out_ch.valid) |-> head.has_b)
    else $error("second result presented for a single-result entry");

endmodule

### design/heat_diffusion_stencil_step_core.sv
// Top level of the FTCS 2D heat equation stencil step over a raster-order grid stream.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries one old cell temperature per request, in raster order over the grid
//   set by grid_columns and grid_rows. out_ch returns new temperatures, also in raster
//   order, one grid row behind the input: a request in row 0 gives nothing, a request
//   at (i,j) gives cell (i-1,j), and a request in the last row also returns its own
//   cell unchanged; frame_last marks the final cell of the grid.
//   Throughput is one request per cycle while in_ch.ready is high; in the last row each
//   request yields two results, so there the out_ch port sets the pace of the input.
//   The first result of a request passes the line buffer read registers, the laplacian
//   registers and the coefficient product registers, then is rounded and saturated
//   into the result queue, from which out_ch presents it.
//   Results wait in an 8-entry queue; in_ch.ready drops once 8 entries are reserved,
//   so a stalled receiver backs up the input without losing anything.
//   Reset (rst_n low, synchronous) zeroes the raster position, loads the default
//   registers and empties the queue; the line buffers are not cleared, and an entry read
//   before it is written never feeds a result. Write cfg_* only while the block is idle.
module heat_diffusion_stencil_step_core #(
  parameter int MAX_COLUMNS = hds_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = hds_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  hds_in_if.sink                            in_ch,
  hds_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [hds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CA     = $clog2(MAX_COLUMNS);
  localparam int RA     = $clog2(MAX_ROWS);
  localparam int SIZE_W = hds_pkg::SIZE_W;
  localparam int COEF_W = hds_pkg::COEF_W;

  logic [SIZE_W-1:0]  grid_columns_r, grid_rows_r;
  logic [COEF_W-1:0]  coef_h_r, coef_v_r;
  logic [CA-1:0]      col_cnt_r, col_last, col_next;
  logic [RA-1:0]      row_cnt_r, row_last;
  logic               last_col, last_row, accept, credit_ok;
  hds_pkg::hds_ctl_t  ctl, s1_ctl_r;
  hds_pkg::temp_t     s1_down_r, centre, right, up, left;
  logic [CA-1:0]      s1_col_r;
  logic               s1_valid_r;
  logic               push;
  hds_pkg::hds_res_t  push_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r <= hds_pkg::SIZE_RST;
      grid_rows_r    <= hds_pkg::SIZE_RST;
      coef_h_r       <= hds_pkg::COEF_RST;
      coef_v_r       <= hds_pkg::COEF_RST;
    end else if (cfg_we) begin
      unique case (hds_pkg::hds_cfg_idx_t'(cfg_index))
        hds_pkg::CFG_GRID_COLUMNS: grid_columns_r <= cfg_data[SIZE_W-1:0];
        hds_pkg::CFG_GRID_ROWS:    grid_rows_r    <= cfg_data[SIZE_W-1:0];
        hds_pkg::CFG_COEF_HORIZ:   coef_h_r       <= cfg_data[COEF_W-1:0];
        hds_pkg::CFG_COEF_VERT:    coef_v_r       <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid size and form the last indexes
  always_comb begin
    if (grid_columns_r < SIZE_W'(hds_pkg::MIN_SIZE)) begin
      col_last = CA'(hds_pkg::MIN_SIZE - 1);
    end else if (32'(grid_columns_r) > MAX_COLUMNS) begin
      col_last = CA'(MAX_COLUMNS - 1);
    end else begin
      col_last = CA'(grid_columns_r - 1'b1);
    end
    if (grid_rows_r < SIZE_W'(hds_pkg::MIN_SIZE)) begin
      row_last = RA'(hds_pkg::MIN_SIZE - 1);
    end else if (32'(grid_rows_r) > MAX_ROWS) begin
      row_last = RA'(MAX_ROWS - 1);
    end else begin
      row_last = RA'(grid_rows_r - 1'b1);
    end
  end

  assign last_col = (col_cnt_r >= col_last);
  assign last_row = (row_cnt_r >= row_last);
  assign col_next = last_col ? col_cnt_r : col_cnt_r + 1'b1;

  assign in_ch.ready = rst_n & credit_ok;
  assign accept      = in_ch.valid & in_ch.ready;

  assign ctl.need     = (row_cnt_r != '0);
  assign ctl.pass     = (row_cnt_r != '0) & last_row;
  assign ctl.last     = last_col;
  assign ctl.interior = (row_cnt_r >= RA'(2)) & (col_cnt_r != '0) & ~last_col;

  // Raster position and stage-1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        if (last_col) begin
          col_cnt_r <= '0;
          row_cnt_r <= last_row ? '0 : row_cnt_r + 1'b1;
        end else begin
          col_cnt_r <= col_cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r  <= ctl;
      s1_down_r <= in_ch.temp_in;
      s1_col_r  <= col_cnt_r;
    end
  end

  hds_linebuf #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_linebuf (
    .clk         (clk),
    .rd_en       (accept),
    .rd_col      (col_cnt_r),
    .rd_col_next (col_next),
    .wr_down     (in_ch.temp_in),
    .wb_en       (s1_valid_r),
    .wb_col      (s1_col_r),
    .centre      (centre),
    .right       (right),
    .up          (up),
    .left        (left)
  );

  hds_stencil u_stencil (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid_r),
    .s1_ctl    (s1_ctl_r),
    .s1_down   (s1_down_r),
    .centre    (centre),
    .right     (right),
    .up        (up),
    .left      (left),
    .coef_h    (coef_h_r),
    .coef_v    (coef_v_r),
    .push      (push),
    .push_data (push_data)
  );

  hds_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (accept & ctl.need),
    .credit_ok (credit_ok),
    .push      (push),
    .push_data (push_data),
    .out_ch    (out_ch)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted request did not enter the pipeline");

  a_interior_needs: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ctl_r.interior) |-> (s1_ctl_r.need && !s1_ctl_r.last))
    else $error("stencil update flagged for a border cell");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (col_cnt_r <= CA'(MAX_COLUMNS - 1)))
    else $error("column count left the line buffer range");

endmodule
